/* rtl/ihex_pkg.sv */
// ihex_pkg: shared types and codes for the intel hex record parser
// no dependencies

package ihex_pkg;

  typedef enum logic [2:0] {
    PH_WAIT  = 3'd0,
    PH_COUNT = 3'd1,
    PH_ADDR  = 3'd2,
    PH_TYPE  = 3'd3,
    PH_DATA  = 3'd4,
    PH_CSUM  = 3'd5,
    PH_SKIP  = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CSUM_BAD  = 3'd1,
    ST_NO_START  = 3'd2,
    ST_BAD_DIGIT = 3'd3,
    ST_TOO_LONG  = 3'd4,
    ST_TRUNCATED = 3'd5
  } status_t;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;

endpackage

/* rtl/intel_hex_record_parser_unit.sv */
// intel_hex_record_parser_unit: decodes one intel hex line, one ascii character per transaction
// depends on ihex_pkg

// Takes one character per cycle, with in_tlast on the line's last character. Each character
// passes an input register, decode and checksum add, and a result register, so
// a character is accepted every cycle and its result (if any) is registered after decode;
// the only limit on rate is backpressure from out_tready. Data bytes come out
// as they are decoded (out_tuser low); a record-done transaction (out_tuser high) carries the
// header fields and a status. After a record-done or an error, characters are dropped until
// the end of the line.
module intel_hex_record_parser_unit
  import ihex_pkg::*;
#(
  parameter int MAX_DATA_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] data_byte, [11:8] byte_index, [19:12] rec_len,
                                  // [35:20] load_address, [43:36] rec_type, [46:44] status
  output logic [0:0]  out_tuser   // [0] kind
);

  localparam int IDXW = $clog2(MAX_DATA_BYTES + 1);
  localparam logic [7:0] MAX_COUNT = 8'(MAX_DATA_BYTES);

  // input stage
  logic       in_valid_r;
  logic [7:0] in_char_r;
  logic       in_last_r;

  // parser state
  phase_t            phase_r, phase_nxt;
  logic [1:0]        digit_pos_r, digit_pos_nxt;
  logic [3:0]        high_nib_r, high_nib_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        count_r, count_nxt;
  logic [15:0]       addr_r, addr_nxt;
  logic [7:0]        type_r, type_nxt;
  logic [IDXW-1:0]   idx_r, idx_nxt;

  // result stage
  logic        out_valid_r;
  logic        kind_r, kind_nxt;
  logic [7:0]  data_byte_r, data_byte_nxt;
  logic [3:0]  byte_index_r, byte_index_nxt;
  logic [7:0]  rec_len_r;
  logic [15:0] load_addr_r;
  logic [7:0]  rec_type_r;
  status_t     status_r, status_nxt;

  logic        out_free;
  logic        proc;
  logic        res_valid;
  logic        fin;
  status_t     fin_status;
  logic        nib_ok;
  logic [3:0]  nib;
  logic [7:0]  dbyte;
  logic [IDXW-1:0] idx_inc;
  logic [7:0]  idx_ext;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || out_free;
  assign proc      = in_valid_r && out_free;

  // hex digit decode, uppercase only
  always_comb begin
    nib_ok = 1'b0;
    nib    = 4'd0;
    if (in_char_r >= CH_ZERO && in_char_r <= CH_NINE) begin
      nib_ok = 1'b1;
      nib    = 4'(in_char_r - CH_ZERO);
    end else if (in_char_r >= CH_UPPER_A && in_char_r <= CH_UPPER_F) begin
      nib_ok = 1'b1;
      nib    = 4'(in_char_r - CH_UPPER_A + 8'd10);
    end
  end

  assign dbyte   = {high_nib_r, nib};
  assign idx_inc = idx_r + IDXW'(1);
  assign idx_ext = 8'(idx_r);

  always_comb begin
    phase_nxt      = phase_r;
    digit_pos_nxt  = digit_pos_r;
    high_nib_nxt   = high_nib_r;
    sum_nxt        = sum_r;
    count_nxt      = count_r;
    addr_nxt       = addr_r;
    type_nxt       = type_r;
    idx_nxt        = idx_r;
    res_valid      = 1'b0;
    fin            = 1'b0;
    fin_status     = ST_OK;
    kind_nxt       = KIND_DONE;
    data_byte_nxt  = 8'd0;
    byte_index_nxt = 4'd0;
    status_nxt     = ST_OK;

    unique case (phase_r) inside
      PH_WAIT: begin
        if (in_char_r != CH_COLON) begin
          fin        = 1'b1;
          fin_status = ST_NO_START;
        end else begin
          sum_nxt       = 8'd0;
          count_nxt     = 8'd0;
          addr_nxt      = 16'd0;
          type_nxt      = 8'd0;
          idx_nxt       = '0;
          digit_pos_nxt = 2'd0;
          high_nib_nxt  = 4'd0;
          phase_nxt     = PH_COUNT;
          if (in_last_r) begin
            fin        = 1'b1;
            fin_status = ST_TRUNCATED;
          end
        end
      end
      PH_SKIP: begin
        if (in_last_r) begin
          phase_nxt = PH_WAIT;
        end
      end
      PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_CSUM: begin
        if (!nib_ok) begin
          fin        = 1'b1;
          fin_status = ST_BAD_DIGIT;
        end else if (!digit_pos_r[0]) begin
          high_nib_nxt  = nib;
          digit_pos_nxt = digit_pos_r + 2'd1;
          if (in_last_r) begin
            fin        = 1'b1;
            fin_status = ST_TRUNCATED;
          end
        end else begin
          sum_nxt       = sum_r + dbyte;
          digit_pos_nxt = digit_pos_r + 2'd1;
          case (phase_r)
            PH_COUNT: begin
              count_nxt     = dbyte;
              digit_pos_nxt = 2'd0;
              phase_nxt     = PH_ADDR;
              if (dbyte > MAX_COUNT) begin
                fin        = 1'b1;
                fin_status = ST_TOO_LONG;
              end else if (in_last_r) begin
                fin        = 1'b1;
                fin_status = ST_TRUNCATED;
              end
            end
            PH_ADDR: begin
              addr_nxt = {addr_r[7:0], dbyte};
              if (digit_pos_r == 2'd3) begin
                digit_pos_nxt = 2'd0;
                phase_nxt     = PH_TYPE;
              end
              if (in_last_r) begin
                fin        = 1'b1;
                fin_status = ST_TRUNCATED;
              end
            end
            PH_TYPE: begin
              type_nxt      = dbyte;
              digit_pos_nxt = 2'd0;
              phase_nxt     = (count_r != 8'd0) ? PH_DATA : PH_CSUM;
              if (in_last_r) begin
                fin        = 1'b1;
                fin_status = ST_TRUNCATED;
              end
            end
            PH_DATA: begin
              if (in_last_r) begin
                fin        = 1'b1;
                fin_status = ST_TRUNCATED;
              end else begin
                res_valid      = 1'b1;
                kind_nxt       = KIND_DATA;
                data_byte_nxt  = dbyte;
                byte_index_nxt = idx_ext[3:0];
                idx_nxt        = idx_inc;
                digit_pos_nxt  = 2'd0;
                if (8'(idx_inc) >= count_r) begin
                  phase_nxt = PH_CSUM;
                end
              end
            end
            default: begin
              fin        = 1'b1;
              fin_status = (sum_nxt == 8'd0) ? ST_OK : ST_CSUM_BAD;
            end
          endcase
        end
      end
      default: begin
        phase_nxt = PH_WAIT;
      end
    endcase

    if (fin) begin
      res_valid     = 1'b1;
      kind_nxt      = KIND_DONE;
      status_nxt    = fin_status;
      phase_nxt     = in_last_r ? PH_WAIT : PH_SKIP;
      digit_pos_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      digit_pos_r <= 2'd0;
      high_nib_r  <= 4'd0;
      sum_r       <= 8'd0;
      count_r     <= 8'd0;
      addr_r      <= 16'd0;
      type_r      <= 8'd0;
      idx_r       <= '0;
    end else if (proc) begin
      phase_r     <= phase_nxt;
      digit_pos_r <= digit_pos_nxt;
      high_nib_r  <= high_nib_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      addr_r      <= addr_nxt;
      type_r      <= type_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= proc && res_valid;
    end
    if (proc && res_valid) begin
      kind_r       <= kind_nxt;
      data_byte_r  <= data_byte_nxt;
      byte_index_r <= byte_index_nxt;
      rec_len_r    <= count_nxt;
      load_addr_r  <= addr_nxt;
      rec_type_r   <= type_nxt;
      status_r     <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {1'b0, status_r, rec_type_r, load_addr_r, rec_len_r,
                       byte_index_r, data_byte_r};

`ifndef SYNTHESIS
  a_data_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_DATA |-> status_r == ST_OK)
    else $error("data transaction with nonzero status");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> 8'(idx_r) < count_r)
    else $error("data index at or past byte count");

  a_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    proc && phase_r == PH_WAIT && in_char_r != CH_COLON
      |=> out_valid_r && kind_r == KIND_DONE && status_r == ST_NO_START)
    else $error("missing start code not reported");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for intel_hex_record_parser_unit, streams hex lines through it
// and checks every output against a built-in line decoder (typed rows: fixed values)
// depends on ihex_pkg and intel_hex_record_parser_unit

module tb;
  import ihex_pkg::*;

  localparam int MAX_BYTES = 16;
  localparam int RANDOM_CHARS = 1000;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  typedef struct {
    logic       kind;
    logic [7:0] data_byte;
    logic [3:0] byte_idx;
    logic [7:0] cnt;
    logic [15:0] addr;
    logic [7:0] rtype;
    status_t    st;
  } ihex_result_t;

  typedef struct {
    string      text;
    bit         typed;
    status_t    st;
    logic [7:0] cnt;
    logic [15:0] addr;
    logic [7:0] rtype;
  } line_case_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] char_in
  logic        in_tlast;   // last_char
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;  // [7:0] data_byte, [11:8] byte_index, [19:12] rec_len,
                           // [35:20] load_address, [43:36] rec_type, [46:44] status
  logic [0:0]  out_tuser;  // [0] kind

  intel_hex_record_parser_unit #(.MAX_DATA_BYTES(MAX_BYTES)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  // line decoder state
  phase_t      ph;
  logic [5:0]  pos;
  logic [3:0]  hi_nib;
  logic [7:0]  csum_acc;
  logic [7:0]  cnt_f;
  logic [15:0] addr_f;
  logic [7:0]  typ_f;
  logic [4:0]  dat_idx;

  ihex_result_t expected_q[$];
  logic [7:0]   line_q[$];
  int           errors = 0;
  int           accepted = 0;
  int           cycles = 0;
  int           hold = 0;
  bit           calm = 1'b0;

  line_case_t dir_rows [18] = '{
    '{"X",                    1'b1, ST_NO_START,  8'h00, 16'h0000, 8'h00},
    '{":",                    1'b1, ST_TRUNCATED, 8'h00, 16'h0000, 8'h00},
    '{":0G",                  1'b1, ST_BAD_DIGIT, 8'h00, 16'h0000, 8'h00},
    '{":0a",                  1'b1, ST_BAD_DIGIT, 8'h00, 16'h0000, 8'h00},
    '{":11",                  1'b1, ST_TOO_LONG,  8'h11, 16'h0000, 8'h00},
    '{":FF",                  1'b1, ST_TOO_LONG,  8'hFF, 16'h0000, 8'h00},
    '{":0F",                  1'b1, ST_TRUNCATED, 8'h0F, 16'h0000, 8'h00},
    '{":01ABCD7F3",           1'b1, ST_TRUNCATED, 8'h01, 16'hABCD, 8'h7F},
    '{":00000001FF",          1'b1, ST_OK,        8'h00, 16'h0000, 8'h01},
    '{":00000001FE",          1'b1, ST_CSUM_BAD,  8'h00, 16'h0000, 8'h01},
    '{":00FFFFFF03",          1'b1, ST_OK,        8'h00, 16'hFFFF, 8'hFF},
    '{":0300300002337A1E",    1'b0, ST_OK,        8'h00, 16'h0000, 8'h00},
    '{":0300300002337A",      1'b0, ST_OK,        8'h00, 16'h0000, 8'h00},
    '{":0300300002337A1FXYZ", 1'b0, ST_OK,        8'h00, 16'h0000, 8'h00},
    '{"#:0",                  1'b0, ST_OK,        8'h00, 16'h0000, 8'h00},
    '{":02FFFF0Ag1",          1'b0, ST_OK,        8'h00, 16'h0000, 8'h00},
    '{":11000",               1'b0, ST_OK,        8'h00, 16'h0000, 8'h00},
    '{"::",                   1'b0, ST_OK,        8'h00, 16'h0000, 8'h00}
  };

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CH_ZERO + 8'(n) : CH_UPPER_A + 8'(n) - 8'd10;
  endfunction

  function automatic ihex_result_t result_of(input logic k, input logic [7:0] b,
                                             input logic [3:0] idx, input status_t s);
    ihex_result_t r;
    r.kind = k;
    r.data_byte = b;
    r.byte_idx = idx;
    r.cnt = cnt_f;
    r.addr = addr_f;
    r.rtype = typ_f;
    r.st = s;
    return r;
  endfunction

  function automatic bit close_record(input status_t s, input bit l, output ihex_result_t r);
    r = result_of(KIND_DONE, 8'h00, 4'h0, s);
    ph = l ? PH_WAIT : PH_SKIP;
    pos = '0;
    return 1'b1;
  endfunction

  function automatic bit decode_char(input logic [7:0] c, input bit l, output ihex_result_t r);
    int nib;
    logic [7:0] b;
    if (ph == PH_WAIT) begin
      if (c != CH_COLON) return close_record(ST_NO_START, l, r);
      csum_acc = '0;
      cnt_f = '0;
      addr_f = '0;
      typ_f = '0;
      dat_idx = '0;
      pos = '0;
      hi_nib = '0;
      ph = PH_COUNT;
      if (l) return close_record(ST_TRUNCATED, l, r);
      return 1'b0;
    end
    if (ph == PH_SKIP) begin
      if (l) ph = PH_WAIT;
      return 1'b0;
    end
    nib = hex_nibble(c);
    if (nib < 0) return close_record(ST_BAD_DIGIT, l, r);
    if (!pos[0]) begin
      hi_nib = nib[3:0];
      pos++;
      if (l) return close_record(ST_TRUNCATED, l, r);
      return 1'b0;
    end
    b = {hi_nib, nib[3:0]};
    pos++;
    csum_acc = csum_acc + b;
    case (ph)
      PH_COUNT: begin
        cnt_f = b;
        pos = '0;
        ph = PH_ADDR;
        if (cnt_f > MAX_BYTES) return close_record(ST_TOO_LONG, l, r);
      end
      PH_ADDR: begin
        addr_f = {addr_f[7:0], b};
        if (pos >= 6'd4) begin
          pos = '0;
          ph = PH_TYPE;
        end
      end
      PH_TYPE: begin
        typ_f = b;
        pos = '0;
        ph = (cnt_f != 8'd0) ? PH_DATA : PH_CSUM;
      end
      PH_DATA: begin
        if (l) return close_record(ST_TRUNCATED, l, r);
        r = result_of(KIND_DATA, b, dat_idx[3:0], ST_OK);
        dat_idx++;
        pos = '0;
        if (8'(dat_idx) >= cnt_f) ph = PH_CSUM;
        return 1'b1;
      end
      default: return close_record((csum_acc == 8'd0) ? ST_OK : ST_CSUM_BAD, l, r);
    endcase
    if (l) return close_record(ST_TRUNCATED, l, r);
    return 1'b0;
  endfunction

  // mostly zero, some short, a few long; always zero while calm is set
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void put_hex(input logic [7:0] b);
    line_q.push_back(hex_char(b[7:4]));
    line_q.push_back(hex_char(b[3:0]));
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return CH_LOWER_A + 8'($urandom_range(0, 5));
      3: return CH_COLON;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void make_random_line();
    int sel, n, nd, cut;
    logic [7:0] sum, b;
    line_q.delete();
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      n = $urandom_range(1, 8);
      repeat (n) line_q.push_back(noise_char());
      return;
    end
    n = ($urandom_range(0, 11) == 0) ? $urandom_range(17, 255) : $urandom_range(0, 16);
    nd = (n > MAX_BYTES) ? 2 : n;
    line_q.push_back(CH_COLON);
    b = 8'(n);
    put_hex(b);
    sum = b;
    repeat (2) begin
      b = 8'($urandom);
      put_hex(b);
      sum = sum + b;
    end
    b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
    put_hex(b);
    sum = sum + b;
    repeat (nd) begin
      b = 8'($urandom);
      put_hex(b);
      sum = sum + b;
    end
    b = -sum;
    if ($urandom_range(0, 9) == 0) b = b ^ 8'($urandom_range(1, 255));
    put_hex(b);
    if (sel < 18) begin
      line_q[$urandom_range(0, line_q.size() - 1)] = noise_char();
    end else if (sel < 26) begin
      cut = $urandom_range(1, line_q.size() - 1);
      while (line_q.size() > cut) void'(line_q.pop_back());
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) line_q.push_back(noise_char());
    end
  endfunction

  task automatic send_line(input bit typed, input ihex_result_t fixed_want);
    ihex_result_t pred;
    bit has;
    bit l;
    int g;
    for (int i = 0; i < line_q.size(); i++) begin
      l = (i == line_q.size() - 1);
      g = pick_gap();
      if (g > 0) begin
        in_tvalid <= 1'b0;
        repeat (g) @(negedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= line_q[i];
      in_tlast <= l;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      has = decode_char(line_q[i], l, pred);
      if (typed) begin
        if (l) expected_q.push_back(fixed_want);
      end else if (has) begin
        expected_q.push_back(pred);
      end
      accepted++;
      @(negedge clk);
    end
  endtask

  task automatic cmp(input string what, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h, got %h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_out
    ihex_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected transaction: expected none, got user %h data %h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = expected_q.pop_front();
        cmp("kind", 16'(want.kind), 16'(out_tuser[0]));
        cmp("data_byte", 16'(want.data_byte), 16'(out_tdata[7:0]));
        cmp("byte_index", 16'(want.byte_idx), 16'(out_tdata[11:8]));
        cmp("rec_len", 16'(want.cnt), 16'(out_tdata[19:12]));
        cmp("load_address", want.addr, out_tdata[35:20]);
        cmp("rec_type", 16'(want.rtype), 16'(out_tdata[43:36]));
        cmp("status", 16'(want.st), 16'(out_tdata[46:44]));
      end
    end
  end

  always @(negedge clk) begin : out_stall
    int g;
    if (hold > 0) begin
      hold <= hold - 1;
      out_tready <= 1'b0;
    end else begin
      g = pick_gap();
      out_tready <= (g == 0);
      hold <= (g > 0) ? g - 1 : 0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    ihex_result_t want;
    int start;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tlast = 1'b0;
    ph = PH_WAIT;
    pos = '0;
    hi_nib = '0;
    csum_acc = '0;
    cnt_f = '0;
    addr_f = '0;
    typ_f = '0;
    dat_idx = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[k]) begin
      line_q.delete();
      for (int i = 0; i < dir_rows[k].text.len(); i++) line_q.push_back(dir_rows[k].text[i]);
      want.kind = KIND_DONE;
      want.data_byte = 8'h00;
      want.byte_idx = 4'h0;
      want.cnt = dir_rows[k].cnt;
      want.addr = dir_rows[k].addr;
      want.rtype = dir_rows[k].rtype;
      want.st = dir_rows[k].st;
      send_line(dir_rows[k].typed, want);
    end

    start = accepted;
    while (accepted - start < RANDOM_CHARS) begin
      if ($urandom_range(0, 15) == 0) calm = ~calm;
      make_random_line();
      send_line(1'b0, want);
    end
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ihex_pkg.sv
rtl/intel_hex_record_parser_unit.sv
tb/tb.sv
